>>> hdl/pip_pkg.sv
// Shared types and constants for the point-in-polygon crossing counter.
`timescale 1ns / 1ps

package pip_pkg;

  // Fixed field widths of the stream payloads and the configuration register.
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 8;
  localparam int OUT_DATA_W = 16;

  // Opcodes carried in the input tuser bit.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } pip_state_e;

endpackage

>>> hdl/point_in_polygon_crossing_count.sv
// Top level of the point-in-polygon ray crossing counter.
`timescale 1ns / 1ps

// Usage:
// The slave stream takes two kinds of transfer, told apart by tuser[0].
// A load (opcode 0) writes vertex (coord_x, coord_y) into slot vertex_index
// (1 to MAX_VERTICES, other slots are ignored) and gives
// no result. A query (opcode 1) carries a test point; the block casts a ray
// to the right and walks slots 1..vertex_count through the vertex RAM, one
// vertex per cycle, feeding a three-stage orientation unit (difference,
// products, sign test). One result transfer follows on the master stream:
// the crossing count and its parity as the inside flag.
// A query occupies the block from acceptance to a valid result; the walk is
// paced by the single RAM read port that delivers one vertex a cycle, and the
// next item is accepted once the result sits in the output register. A
// stalled receiver holds that register; loads and a further query are still
// taken, and a second result waits until the first is gone. The user must
// write vertex_count through cfg_we_i/cfg_wdata_i while idle; the block does
// not enforce it. Reset clears the control state and sets vertex_count to 3;
// the vertex store holds no defined contents until each slot is written.
module point_in_polygon_crossing_count
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 128,
  parameter int COORD_BITS   = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // tdata: vertex_index [7:0], coord_x, coord_y, zero fill up to whole bytes
  input  logic [((IDX_W+2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  // tuser: opcode
  input  logic [0:0]                                  s_axis_tuser_i,
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // tdata: crossing_count [7:0], is_inside [8], zero fill
  output logic [OUT_DATA_W-1:0]                       m_axis_tdata_o,
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  input  logic                                        cfg_we_i,
  input  logic [CNT_W-1:0]                            cfg_wdata_i
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int IW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
  localparam int DW = COORD_BITS + 2;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  // Ray endpoint, just beyond the largest coordinate.
  localparam logic signed [DW-1:0] RAY_END_X = {2'b00, 1'b1, {(COORD_BITS-1){1'b0}}};

  pip_state_e state_q, state_d;

  logic [CNT_W-1:0] vertex_count_q;
  logic [IW-1:0]    n_clamp, n_m1;
  logic [IW-1:0]    rd_cnt_q, rd_cnt_d;
  logic [CNT_W-1:0] count_q;

  logic                  in_xfer, is_load, is_query, slot_ok, ram_we;
  logic [IW-1:0]         slot_ext;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [2*COORD_BITS-1:0] ram_rdata;

  logic [COORD_BITS-1:0] in_x, in_y;
  logic signed [DW-1:0]  tx_q, ty_q, px_q, py_q;
  logic signed [DW-1:0]  vx, vy;
  logic                  skip, cond_ray;

  logic                  s1_vld_q, s2_vld_q, s3_vld_q;
  logic                  rd_issue;
  logic signed [DW-1:0]  d_pv_x_q, d_tv_y_q, d_tv_x_q, d_pv_y_q, d_ev_x_q;
  logic                  s2_ray_q, s3_ray_q;
  logic signed [PW-1:0]  prod_a_q, prod_b_q, prod_c_q;
  logic signed [SW-1:0]  orient_t, orient_e;
  logic                  same_side, meet;

  logic                  out_load;
  logic                  m_vld_q;
  logic [CNT_W-1:0]      out_cnt_q;
  logic                  out_in_q;

  // ---------------------------------------------------------------------------
  // Input decode and configuration.
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_load  = in_xfer && (s_axis_tuser_i[0] == OP_LOAD);
  assign is_query = in_xfer && (s_axis_tuser_i[0] == OP_QUERY);

  assign in_x = s_axis_tdata_i[IDX_W +: COORD_BITS];
  assign in_y = s_axis_tdata_i[IDX_W+COORD_BITS +: COORD_BITS];

  assign slot_ext  = IW'(s_axis_tdata_i[IDX_W-1:0]);
  assign slot_ok   = (slot_ext != '0) && (slot_ext <= IW'(MAX_VERTICES));
  assign ram_we    = is_load && slot_ok;
  assign ram_waddr = AW'(slot_ext - IW'(1));

  assign n_clamp = (IW'(vertex_count_q) > IW'(MAX_VERTICES)) ? IW'(MAX_VERTICES)
                                                             : IW'(vertex_count_q);
  assign n_m1    = n_clamp - IW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RESET;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Vertex store: y in the upper half, x in the lower half of each word.
  pip_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_y, in_x}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Walk sequencer. While idle the RAM already reads the last slot, which
  // seeds the previous-vertex register in the prime cycle.
  always_comb begin
    state_d   = state_q;
    rd_cnt_d  = rd_cnt_q;
    ram_raddr = n_m1[AW-1:0];
    rd_issue  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (is_query) begin
          state_d = (n_clamp == '0) ? ST_FINISH : ST_PRIME;
        end
      end
      ST_PRIME: begin
        ram_raddr = '0;
        rd_issue  = 1'b1;
        rd_cnt_d  = IW'(1);
        state_d   = (n_m1 == '0) ? ST_DRAIN : ST_WALK;
      end
      ST_WALK: begin
        ram_raddr = rd_cnt_q[AW-1:0];
        rd_issue  = 1'b1;
        rd_cnt_d  = rd_cnt_q + IW'(1);
        if (rd_cnt_q == n_m1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q && !s3_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_vld_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_cnt_q <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      s1_vld_q <= rd_issue;
      s2_vld_q <= s1_vld_q && !skip;
      s3_vld_q <= s2_vld_q;
      if (is_query) begin
        count_q <= '0;
      end else if (s3_vld_q && meet) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: vertex from RAM, skip test against the ray and differences.
  assign vx = {{2{ram_rdata[COORD_BITS-1]}}, ram_rdata[COORD_BITS-1:0]};
  assign vy = {{2{ram_rdata[2*COORD_BITS-1]}}, ram_rdata[2*COORD_BITS-1:COORD_BITS]};

  assign skip = (vy == ty_q);
  // The edge fails the ray's side test only when both ends lie strictly on
  // the same side of the ray line.
  assign cond_ray = (py_q == ty_q) || ((vy > ty_q) != (py_q > ty_q));

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      tx_q <= {{2{in_x[COORD_BITS-1]}}, in_x};
      ty_q <= {{2{in_y[COORD_BITS-1]}}, in_y};
    end
    if (state_q == ST_PRIME) begin
      px_q <= vx;
      py_q <= vy;
    end else if (s1_vld_q && !skip) begin
      px_q <= vx;
      py_q <= vy;
    end
    d_pv_x_q <= px_q - vx;
    d_tv_y_q <= ty_q - vy;
    d_tv_x_q <= tx_q - vx;
    d_pv_y_q <= py_q - vy;
    d_ev_x_q <= RAY_END_X - vx;
    s2_ray_q <= cond_ray;
  end

  // Stage 2: the three orientation products.
  always_ff @(posedge clk_i) begin
    prod_a_q <= PW'(d_pv_x_q) * PW'(d_tv_y_q);
    prod_b_q <= PW'(d_tv_x_q) * PW'(d_pv_y_q);
    prod_c_q <= PW'(d_ev_x_q) * PW'(d_pv_y_q);
    s3_ray_q <= s2_ray_q;
  end

  // Stage 3: orientation of the test point and of the ray end against the edge.
  assign orient_t  = SW'(prod_a_q) - SW'(prod_b_q);
  assign orient_e  = SW'(prod_a_q) - SW'(prod_c_q);
  assign same_side = ((orient_t > 0) && (orient_e > 0)) ||
                     ((orient_t < 0) && (orient_e < 0));
  assign meet      = s3_ray_q && !same_side;

  // ---------------------------------------------------------------------------
  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (out_load) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cnt_q <= count_q;
      out_in_q  <= count_q[0];
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-CNT_W-1){1'b0}}, out_in_q, out_cnt_q};

  // ---------------------------------------------------------------------------
  // Assertions.
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_vld_q && !s2_vld_q && !s3_vld_q))
    else $error("walk pipeline not empty while idle");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (rd_cnt_q <= n_m1))
    else $error("walk read index beyond vertex count");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("vertex store written during a query");

  a_finish_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && (!m_vld_q || m_axis_tready_i)) |=>
      (m_vld_q && state_q == ST_IDLE))
    else $error("finished query did not reach the output register");

endmodule

>>> hdl/pip_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
